### hw/rtl/sbr_pkg.sv
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared types, codes and sizes of the synchronization register bank.
// ----------------------------------------------------------------------------
package sbr_pkg;

  localparam int CLUSTERS         = 4;
  localparam int REGS_PER_CLUSTER = 64;

  localparam int BANK_SLOTS  = CLUSTERS * REGS_PER_CLUSTER;
  localparam int GROUP_BYTES = REGS_PER_CLUSTER * 4;
  localparam int BANK_BYTES  = BANK_SLOTS * 4;

  localparam int ADDR_W = 10;
  localparam int DATA_W = 8;
  localparam int SLOT_W = $clog2(BANK_SLOTS);
  localparam int REG_W  = $clog2(REGS_PER_CLUSTER);
  localparam int CALC_W = (($clog2(BANK_BYTES) > ADDR_W) ? $clog2(BANK_BYTES) : ADDR_W) + 1;

  // Allocation search: candidates of one parity, in groups of four.
  localparam int NCAND   = (REGS_PER_CLUSTER + 1) / 2;
  localparam int NGRP    = (NCAND + 3) / 4;
  localparam int ROW_PAD = NGRP * 8;
  localparam int GRP_W   = (NGRP > 1) ? $clog2(NGRP) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_WRITE   = 2'd2;
  localparam logic [1:0] REQ_READ    = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_FREE  = 2'd1;
  localparam logic [1:0] STAT_BAD_ADDR = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [1:0]        cluster;
    logic              incr_kind;
    logic [ADDR_W-1:0] byte_address;
    logic [DATA_W-1:0] write_data;
  } sbr_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] alloc_address;
    logic [DATA_W-1:0] read_data;
  } sbr_out_t;

  // Classified request as it travels from the front end to the executor.
  typedef struct packed {
    logic [1:0]        req_type;
    logic              bad_addr;
    logic              incr_kind;
    logic [SLOT_W-1:0] row_base;
    logic [SLOT_W-1:0] slot_idx;
    logic [REG_W-1:0]  reg_idx;
    logic [CALC_W-1:0] byte_base;
    logic [DATA_W-1:0] write_data;
  } sbr_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } sbr_state_t;

endpackage

### hw/rtl/sbr_ram.sv
// ----------------------------------------------------------------------------
// sbr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### hw/rtl/sbr_front.sv
// ----------------------------------------------------------------------------
// sbr_front
// Request front end: checks cluster and address range, derives slot indexes.
// ----------------------------------------------------------------------------
module sbr_front (
  input  logic             start,
  input  logic             full,
  input  sbr_pkg::sbr_in_t in_item,
  output logic             push,
  output sbr_pkg::sbr_cmd_t cmd
);

  logic                       cl_ok;
  logic                       in_range;
  logic [sbr_pkg::CALC_W-1:0] addr_ext;
  logic [sbr_pkg::CALC_W-1:0] byte_base;
  logic [sbr_pkg::CALC_W-1:0] row_base;
  logic [sbr_pkg::CALC_W-1:0] offset;
  logic [sbr_pkg::CALC_W-1:0] slot_full;
  logic [sbr_pkg::REG_W-1:0]  reg_idx;

  always_comb begin
    cl_ok     = int'(in_item.cluster) < sbr_pkg::CLUSTERS;
    addr_ext  = sbr_pkg::CALC_W'(in_item.byte_address);
    byte_base = sbr_pkg::CALC_W'(in_item.cluster) * sbr_pkg::CALC_W'(sbr_pkg::GROUP_BYTES);
    row_base  = sbr_pkg::CALC_W'(in_item.cluster)
                * sbr_pkg::CALC_W'(sbr_pkg::REGS_PER_CLUSTER);
    offset    = addr_ext - byte_base;
    in_range  = (addr_ext >= byte_base) && (offset < sbr_pkg::CALC_W'(sbr_pkg::GROUP_BYTES));
    // drop the two low address bits
    reg_idx   = offset[sbr_pkg::REG_W+1:2];
    slot_full = row_base + sbr_pkg::CALC_W'(reg_idx);

    push          = start && !full;
    cmd.req_type  = in_item.req_type;
    cmd.incr_kind = in_item.incr_kind;
    cmd.write_data = in_item.write_data;
    cmd.byte_base = byte_base;
    cmd.reg_idx   = reg_idx;
    cmd.bad_addr  = !cl_ok || ((in_item.req_type != sbr_pkg::REQ_ALLOC) && !in_range);
    cmd.row_base  = cl_ok ? row_base[sbr_pkg::SLOT_W-1:0] : '0;
    cmd.slot_idx  = cmd.bad_addr ? '0 : slot_full[sbr_pkg::SLOT_W-1:0];
  end

endmodule

### hw/rtl/sbr_queue.sv
// ----------------------------------------------------------------------------
// sbr_queue
// Short command queue between the front end and the executor.
// ----------------------------------------------------------------------------
module sbr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sbr_pkg::sbr_cmd_t cmd_in,
  input  logic              pop,
  output sbr_pkg::sbr_cmd_t cmd_out,
  output logic              full,
  output logic              empty
);

  sbr_pkg::sbr_cmd_t          mem_r [sbr_pkg::QUEUE_DEPTH];
  logic [sbr_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [sbr_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [sbr_pkg::QPTR_W:0]   count_r, count_nxt;

  always_comb begin
    full       = count_r == (sbr_pkg::QPTR_W+1)'(sbr_pkg::QUEUE_DEPTH);
    empty      = count_r == '0;
    cmd_out    = mem_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == sbr_pkg::QPTR_W'(sbr_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == sbr_pkg::QPTR_W'(sbr_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (sbr_pkg::QPTR_W+1)'(sbr_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

endmodule

### hw/rtl/sbr_exec.sv
// ----------------------------------------------------------------------------
// sbr_exec
// Executor: slot allocation search, in-use bits and register read-modify-write.
// ----------------------------------------------------------------------------
module sbr_exec (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              empty,
  input  sbr_pkg::sbr_cmd_t head,
  output logic              pop,
  output logic              out_valid,
  output sbr_pkg::sbr_out_t out_result
);

  sbr_pkg::sbr_state_t state_r, state_nxt;
  sbr_pkg::sbr_cmd_t   cur_r;

  logic [sbr_pkg::BANK_SLOTS-1:0] in_use_r, in_use_nxt;
  logic [sbr_pkg::BANK_SLOTS-1:0] vld_r, vld_nxt;
  logic                           vld_rd_r;

  logic [sbr_pkg::NGRP-1:0]       grp_free_r, grp_free_nxt;
  logic [sbr_pkg::NGRP-1:0][1:0]  grp_pick_r, grp_pick_nxt;
  logic [sbr_pkg::ROW_PAD-1:0]    row;
  logic                           cand_free;

  logic                       found;
  logic [sbr_pkg::GRP_W-1:0]  sel_g;
  logic [sbr_pkg::REG_W-1:0]  alloc_reg;
  logic [sbr_pkg::SLOT_W-1:0] alloc_slot;
  logic [sbr_pkg::CALC_W-1:0] alloc_byte;

  logic                       ram_we;
  logic [sbr_pkg::DATA_W-1:0] ram_wdata;
  logic [sbr_pkg::DATA_W-1:0] ram_q;
  logic [sbr_pkg::DATA_W-1:0] old_val;

  logic                       out_valid_r, out_valid_nxt;
  sbr_pkg::sbr_out_t          out_res_r, out_res_nxt;

  sbr_ram #(
    .WIDTH(sbr_pkg::DATA_W),
    .DEPTH(sbr_pkg::BANK_SLOTS)
  ) u_value_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cur_r.slot_idx),
    .wdata(ram_wdata),
    .raddr(head.slot_idx),
    .rdata(ram_q)
  );

  // First search level: per group of four candidates, any free and which one.
  always_comb begin
    row = '1;
    row[sbr_pkg::REGS_PER_CLUSTER-1:0] =
      in_use_r[head.row_base +: sbr_pkg::REGS_PER_CLUSTER];
    grp_free_nxt = '0;
    grp_pick_nxt = '0;
    cand_free    = 1'b0;
    for (int g = 0; g < sbr_pkg::NGRP; g++) begin
      for (int j = 3; j >= 0; j--) begin
        cand_free = !row[g*8 + j*2 + int'(head.incr_kind)];
        if (cand_free) begin
          grp_free_nxt[g] = 1'b1;
          grp_pick_nxt[g] = 2'(j);
        end
      end
    end
  end

  // Second search level: lowest group with a free candidate.
  always_comb begin
    found = |grp_free_r;
    sel_g = '0;
    for (int g = sbr_pkg::NGRP - 1; g >= 0; g--) begin
      if (grp_free_r[g]) begin
        sel_g = sbr_pkg::GRP_W'(g);
      end
    end
    alloc_reg  = sbr_pkg::REG_W'({sel_g, grp_pick_r[sel_g], cur_r.incr_kind});
    alloc_slot = cur_r.row_base + sbr_pkg::SLOT_W'(alloc_reg);
    alloc_byte = cur_r.byte_base + (sbr_pkg::CALC_W'(alloc_reg) << 2);
  end

  always_comb begin
    state_nxt     = state_r;
    pop           = 1'b0;
    in_use_nxt    = in_use_r;
    vld_nxt       = vld_r;
    ram_we        = 1'b0;
    ram_wdata     = '0;
    out_valid_nxt = 1'b0;
    out_res_nxt   = '0;
    // an entry never written since reset reads as zero
    old_val       = vld_rd_r ? ram_q : '0;

    unique case (state_r)
      sbr_pkg::S_IDLE: begin
        if (!empty) begin
          pop       = 1'b1;
          state_nxt = sbr_pkg::S_EXEC;
        end
      end
      sbr_pkg::S_EXEC: begin
        state_nxt     = sbr_pkg::S_IDLE;
        out_valid_nxt = 1'b1;
        if (cur_r.bad_addr) begin
          out_res_nxt.status = sbr_pkg::STAT_BAD_ADDR;
        end else begin
          unique case (cur_r.req_type)
            sbr_pkg::REQ_ALLOC: begin
              if (found) begin
                in_use_nxt[alloc_slot]    = 1'b1;
                out_res_nxt.alloc_address = alloc_byte[sbr_pkg::ADDR_W-1:0];
              end else begin
                out_res_nxt.status = sbr_pkg::STAT_NO_FREE;
              end
            end
            sbr_pkg::REQ_RELEASE: begin
              in_use_nxt[cur_r.slot_idx] = 1'b0;
            end
            sbr_pkg::REQ_WRITE: begin
              ram_we                = 1'b1;
              vld_nxt[cur_r.slot_idx] = 1'b1;
              // slot indexes that are a multiple of eight take a plain set
              ram_wdata = (cur_r.reg_idx[2:0] != 3'd0) ? old_val + cur_r.write_data
                        : cur_r.write_data;
            end
            sbr_pkg::REQ_READ: begin
              vld_nxt[cur_r.slot_idx] = 1'b0;
              out_res_nxt.read_data   = old_val;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = sbr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbr_pkg::S_IDLE;
      in_use_r    <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r      <= head;
      vld_rd_r   <= vld_r[head.slot_idx];
      grp_free_r <= grp_free_nxt;
      grp_pick_r <= grp_pick_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_res_r;

  a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == sbr_pkg::S_EXEC))
    else $error("result beat without an executed request");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status != sbr_pkg::STAT_OK) |->
      (out_res_r.alloc_address == '0 && out_res_r.read_data == '0))
    else $error("failed request returned nonzero payload");

  a_alloc_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sbr_pkg::S_EXEC && cur_r.req_type == sbr_pkg::REQ_ALLOC &&
     !cur_r.bad_addr && found) |=> in_use_r[$past(alloc_slot)])
    else $error("allocated slot not marked in use");

endmodule

### hw/rtl/sync_register_bank.sv
// ----------------------------------------------------------------------------
// sync_register_bank
// Per-cluster synchronization registers with slot allocation.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (allocate, release, write, read) enter on in_item and are taken
//   at a clock edge with start high and busy low. A front end checks the
//   cluster and address and places the request in a two-entry queue; the
//   executor drains the queue one request at a time.
//   Each request yields one result beat: out_valid is high for exactly one
//   cycle with out_result holding status, allocated address and read byte.
//   The receiver cannot stall the result channel.
//   An accepted request is queued, popped in S_IDLE, executed in S_EXEC and
//   its result registered. The lookup / read-modify-write pair on the
//   single-port-write value RAM keeps the executor from taking a new request
//   before the last is done. busy rises while the queue is full.
//   Reset (rst_n low, synchronous) frees every slot and zeroes every register
//   at once through per-entry flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sync_register_bank (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sbr_pkg::sbr_in_t  in_item,
  output logic              out_valid,
  output sbr_pkg::sbr_out_t out_result
);

  logic              push;
  logic              pop;
  logic              full;
  logic              empty;
  sbr_pkg::sbr_cmd_t cmd_in;
  sbr_pkg::sbr_cmd_t cmd_head;

  sbr_front u_front (
    .start  (start),
    .full   (full),
    .in_item(in_item),
    .push   (push),
    .cmd    (cmd_in)
  );

  sbr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .cmd_in (cmd_in),
    .pop    (pop),
    .cmd_out(cmd_head),
    .full   (full),
    .empty  (empty)
  );

  sbr_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .head      (cmd_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  assign busy = full;

endmodule

### tb/tb_sync_register_bank.sv
// ----------------------------------------------------------------------------
// tb_sync_register_bank
// Self-checking bench for the synchronization register bank: a directed set
// of requests, then random allocate / release / write / read traffic with
// allocation bursts, checked beat by beat against a behavioral bank model.
// ----------------------------------------------------------------------------
module tb_sync_register_bank;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1450;
  localparam int QUIET_TAIL   = 200;
  localparam int CYCLE_LIMIT  = 120000;

  class sbr_scoreboard;
    bit                slot_taken [sbr_pkg::BANK_SLOTS];
    logic [7:0]        slot_byte  [sbr_pkg::BANK_SLOTS];
    sbr_pkg::sbr_out_t pending_results[$];
    int unsigned       mismatches;
    int unsigned       results_seen;
    int unsigned       req_seen  [4];
    int unsigned       stat_seen [4];

    function new();
      foreach (slot_taken[i]) begin
        slot_taken[i] = 1'b0;
        slot_byte[i]  = '0;
      end
      foreach (req_seen[i]) begin
        req_seen[i]  = 0;
        stat_seen[i] = 0;
      end
      mismatches   = 0;
      results_seen = 0;
    endfunction

    // Apply one request to the bank image and return its result.
    function sbr_pkg::sbr_out_t bank_response(sbr_pkg::sbr_in_t req);
      sbr_pkg::sbr_out_t rsp;
      int                base;
      int                offs;
      int                reg_i;
      int                idx;
      rsp = '0;
      if (int'(req.cluster) >= sbr_pkg::CLUSTERS) begin
        rsp.status = sbr_pkg::STAT_BAD_ADDR;
        return rsp;
      end
      if (req.req_type == sbr_pkg::REQ_ALLOC) begin
        rsp.status = sbr_pkg::STAT_NO_FREE;
        for (int r = int'(req.incr_kind); r < sbr_pkg::REGS_PER_CLUSTER; r += 2) begin
          idx = int'(req.cluster) * sbr_pkg::REGS_PER_CLUSTER + r;
          if (!slot_taken[idx]) begin
            slot_taken[idx]   = 1'b1;
            rsp.status        = sbr_pkg::STAT_OK;
            rsp.alloc_address =
              sbr_pkg::ADDR_W'(int'(req.cluster) * sbr_pkg::GROUP_BYTES + r * 4);
            break;
          end
        end
        return rsp;
      end
      base = int'(req.cluster) * sbr_pkg::GROUP_BYTES;
      offs = int'(req.byte_address) - base;
      if (offs < 0 || offs >= sbr_pkg::GROUP_BYTES) begin
        rsp.status = sbr_pkg::STAT_BAD_ADDR;
        return rsp;
      end
      reg_i = offs / 4;
      idx   = int'(req.cluster) * sbr_pkg::REGS_PER_CLUSTER + reg_i;
      case (req.req_type)
        sbr_pkg::REQ_RELEASE: begin
          slot_taken[idx] = 1'b0;
        end
        sbr_pkg::REQ_WRITE: begin
          if (reg_i % 8 != 0) slot_byte[idx] = slot_byte[idx] + req.write_data;
          else slot_byte[idx] = req.write_data;
        end
        default: begin
          rsp.read_data  = slot_byte[idx];
          slot_byte[idx] = '0;
        end
      endcase
      return rsp;
    endfunction

    function void note_request(sbr_pkg::sbr_in_t req);
      req_seen[req.req_type]++;
      pending_results.push_back(bank_response(req));
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    endfunction

    function void check_result(sbr_pkg::sbr_out_t got);
      sbr_pkg::sbr_out_t want;
      results_seen++;
      stat_seen[got.status]++;
      if (pending_results.size() == 0) begin
        report("unexpected beat", 0, got);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.alloc_address !== want.alloc_address)
        report("alloc_address", want.alloc_address, got.alloc_address);
      if (got.read_data !== want.read_data) report("read_data", want.read_data, got.read_data);
    endfunction
  endclass

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  sbr_pkg::sbr_in_t  in_item = '0;
  logic              out_valid;
  sbr_pkg::sbr_out_t out_result;

  sbr_scoreboard sb = new();
  int unsigned   cycle_count = 0;
  int unsigned   burst_left  = 0;
  logic [1:0]    burst_cluster;
  logic          burst_kind;

  sync_register_bank i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Both channels are sampled at the edge, before this edge's updates land.
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && start && !busy) sb.note_request(in_item);
    if (rst_n && out_valid) sb.check_result(out_result);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_count, sb.pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic sbr_pkg::sbr_in_t make_req(logic [1:0] kind_of_req, logic [1:0] cl,
                                                logic incr, int addr, logic [7:0] data);
    sbr_pkg::sbr_in_t req;
    req.req_type     = kind_of_req;
    req.cluster      = cl;
    req.incr_kind    = incr;
    req.byte_address = sbr_pkg::ADDR_W'(addr);
    req.write_data   = data;
    return req;
  endfunction

  function automatic sbr_pkg::sbr_in_t random_request();
    sbr_pkg::sbr_in_t req;
    int               pick;
    int               slot;
    req = sbr_pkg::sbr_in_t'($urandom);
    case ($urandom_range(0, 7))
      0:       req.write_data = 8'h00;
      1:       req.write_data = 8'hFF;
      default: req.write_data = 8'($urandom);
    endcase
    if (burst_left == 0 && $urandom_range(0, 199) == 0) begin
      burst_left    = 34;
      burst_cluster = 2'($urandom);
      burst_kind    = 1'($urandom);
    end
    // Run one parity of a cluster dry to reach the no-free-slot path.
    if (burst_left != 0) begin
      burst_left--;
      req.req_type  = sbr_pkg::REQ_ALLOC;
      req.cluster   = burst_cluster;
      req.incr_kind = burst_kind;
      return req;
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) return req;
    if (pick < 40) req.req_type = sbr_pkg::REQ_ALLOC;
    else if (pick < 55) req.req_type = sbr_pkg::REQ_RELEASE;
    else if (pick < 78) req.req_type = sbr_pkg::REQ_WRITE;
    else req.req_type = sbr_pkg::REQ_READ;
    // Keep half the accesses on a few hot registers so reads see written data.
    slot = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                       : $urandom_range(0, sbr_pkg::REGS_PER_CLUSTER - 1);
    req.byte_address =
      sbr_pkg::ADDR_W'(int'(req.cluster) * sbr_pkg::GROUP_BYTES + slot * 4);
    if ($urandom_range(0, 7) == 0) req.byte_address[1:0] = 2'($urandom);
    return req;
  endfunction

  // Present one beat and hold it until the block takes it.
  task automatic send_request(input sbr_pkg::sbr_in_t req);
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    sbr_pkg::sbr_in_t directed[$];
    int               total;
    int               n;
    directed.push_back(make_req(sbr_pkg::REQ_ALLOC,   2'd0, 1'b0, 0,    8'h00));
    directed.push_back(make_req(sbr_pkg::REQ_ALLOC,   2'd0, 1'b1, 0,    8'h00));
    directed.push_back(make_req(sbr_pkg::REQ_ALLOC,   2'd3, 1'b1, 1023, 8'hFF));
    directed.push_back(make_req(sbr_pkg::REQ_WRITE,   2'd0, 1'b0, 0,    8'hA5));
    directed.push_back(make_req(sbr_pkg::REQ_WRITE,   2'd0, 1'b0, 0,    8'h11));
    directed.push_back(make_req(sbr_pkg::REQ_WRITE,   2'd0, 1'b0, 4,    8'hFF));
    // unaligned address, add wraps past 255
    directed.push_back(make_req(sbr_pkg::REQ_WRITE,   2'd0, 1'b0, 6,    8'h02));
    directed.push_back(make_req(sbr_pkg::REQ_READ,    2'd0, 1'b0, 7,    8'h00));
    directed.push_back(make_req(sbr_pkg::REQ_READ,    2'd0, 1'b0, 4,    8'h00));
    directed.push_back(make_req(sbr_pkg::REQ_READ,    2'd0, 1'b0, 0,    8'h00));
    // unallocated register at the top of the bank
    directed.push_back(make_req(sbr_pkg::REQ_WRITE,   2'd3, 1'b0, 1023, 8'hFF));
    directed.push_back(make_req(sbr_pkg::REQ_READ,    2'd3, 1'b1, 1023, 8'hFF));
    // addresses outside the cluster's group
    directed.push_back(make_req(sbr_pkg::REQ_WRITE,   2'd1, 1'b0, 255,  8'h5A));
    directed.push_back(make_req(sbr_pkg::REQ_READ,    2'd0, 1'b0, 256,  8'h00));
    directed.push_back(make_req(sbr_pkg::REQ_RELEASE, 2'd2, 1'b0, 0,    8'h00));
    directed.push_back(make_req(sbr_pkg::REQ_RELEASE, 2'd3, 1'b1, 767,  8'hFF));
    // release, then release the now free slot, then take it again
    directed.push_back(make_req(sbr_pkg::REQ_RELEASE, 2'd0, 1'b0, 4,    8'h00));
    directed.push_back(make_req(sbr_pkg::REQ_RELEASE, 2'd0, 1'b0, 4,    8'h00));
    directed.push_back(make_req(sbr_pkg::REQ_ALLOC,   2'd0, 1'b1, 4,    8'h00));
    directed.push_back(make_req(sbr_pkg::REQ_WRITE,   2'd1, 1'b0, 288,  8'h00));
    directed.push_back(make_req(sbr_pkg::REQ_WRITE,   2'd2, 1'b0, 548,  8'h80));
    directed.push_back(make_req(sbr_pkg::REQ_ALLOC,   2'd2, 1'b0, 1023, 8'hFF));
    directed.push_back(make_req(sbr_pkg::REQ_READ,    2'd2, 1'b0, 548,  8'h00));
    directed.push_back(make_req(sbr_pkg::REQ_WRITE,   2'd0, 1'b1, 0,    8'hFF));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    total = directed.size() + RANDOM_ITEMS;
    for (n = 0; n < total; n++) begin
      if (n < directed.size()) send_request(directed[n]);
      else send_request(random_request());
      // Idle in windows, none over the tail of the run.
      if (n < total - QUIET_TAIL && (n / 50) % 3 != 2 && $urandom_range(0, 3) == 0)
        pause_sender($urandom_range(1, 6));
    end
    start <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d requests: %0d allocate, %0d release, %0d write, %0d read",
             sb.req_seen[0] + sb.req_seen[1] + sb.req_seen[2] + sb.req_seen[3],
             sb.req_seen[sbr_pkg::REQ_ALLOC], sb.req_seen[sbr_pkg::REQ_RELEASE],
             sb.req_seen[sbr_pkg::REQ_WRITE], sb.req_seen[sbr_pkg::REQ_READ]);
    $display("%0d results: %0d ok, %0d no free slot, %0d bad address, %0d mismatches",
             sb.results_seen, sb.stat_seen[sbr_pkg::STAT_OK],
             sb.stat_seen[sbr_pkg::STAT_NO_FREE],
             sb.stat_seen[sbr_pkg::STAT_BAD_ADDR], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sync_register_bank.f
hw/rtl/sbr_pkg.sv
hw/rtl/sbr_ram.sv
hw/rtl/sbr_front.sv
hw/rtl/sbr_queue.sv
hw/rtl/sbr_exec.sv
hw/rtl/sync_register_bank.sv
tb/tb_sync_register_bank.sv
